// ----- hdl/rrw_pkg.sv -----
// Shared types, constants and command/status structs for the rotating rainbow wave unit.
// Used by rrw_pix_if, the controller, the datapath, the divider and the top level.
`timescale 1ns / 1ps

package rrw_pkg;

    localparam int MAX_LEDS      = 64;
    localparam int MIN_LEDS      = 6;
    localparam int CNT_W         = 7;
    localparam int IDX_W         = 6;
    localparam int LVL_W         = 8;
    localparam int SECTORS       = 6;
    localparam int SECT_W        = 3;
    localparam int WAVES         = 3;
    localparam int WAVE_REACH    = 3;
    localparam int REL_W         = 6;
    localparam int BASE_W        = 4;
    localparam int THIRD_W       = 5;
    localparam int P_W           = 4;
    localparam int ADD_W         = 11;
    localparam int FULL_LEVEL    = 255;
    localparam int LED_COUNT_RST = 60;
    localparam int MAX_LEVEL_RST = 120;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 8;

    // Reciprocal constants: (n * DIV6_MUL) >> RECIP_SHIFT equals n / 6 and
    // (n * DIV3_MUL) >> RECIP_SHIFT equals n / 3 for every n below 128.
    localparam int DIV6_MUL      = 43;
    localparam int DIV3_MUL      = 86;
    localparam int RECIP_SHIFT   = 8;
    localparam int PROD_W        = 13;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LED_COUNT = 1'b0;
    localparam t_cfg_idx CFG_MAX_LEVEL = 1'b1;

    typedef logic [SECT_W-1:0] t_sector;
    localparam t_sector SEC_GREEN_UP   = 3'd0;
    localparam t_sector SEC_RED_DOWN   = 3'd1;
    localparam t_sector SEC_BLUE_UP    = 3'd2;
    localparam t_sector SEC_GREEN_DOWN = 3'd3;
    localparam t_sector SEC_RED_UP     = 3'd4;
    localparam t_sector SEC_BLUE_DOWN  = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV_A,
        S_DIV_B,
        S_SEEK,
        S_MUL,
        S_RUN
    } t_state;

    typedef struct packed {
        logic start;
        logic prep;
        logic div_go_a;
        logic take_a;
        logic div_go_b;
        logic take_b;
        logic seek;
        logic mul;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic slot_free;
        logic last_pixel;
    } t_status;

endpackage

// ----- hdl/rrw_tick_if.sv -----
// Valid/ready channel that carries one animation tick request.
// Depends on nothing else.
`timescale 1ns / 1ps

interface rrw_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

// ----- hdl/rrw_pix_if.sv -----
// Valid/ready channel that carries one LED colour of a frame.
// Depends on rrw_pkg for the field widths.
`timescale 1ns / 1ps

interface rrw_pix_if;
    logic                          valid;
    logic                          ready;
    logic [rrw_pkg::IDX_W-1:0]     led_index;
    logic [rrw_pkg::LVL_W-1:0]     red;
    logic [rrw_pkg::LVL_W-1:0]     green;
    logic [rrw_pkg::LVL_W-1:0]     blue;
    logic                          last;

    modport source (output valid, output led_index, output red, output green, output blue,
                    output last, input ready);
    modport sink (input valid, input led_index, input red, input green, input blue,
                  input last, output ready);
endinterface

// ----- hdl/rotating_rainbow_wave_pattern_unit.sv -----
// Top level of the rotating rainbow wave pattern unit: controller plus datapath.
// Depends on rrw_pkg, rrw_tick_if, rrw_pix_if, rrw_ctrl and rrw_dpath.
//
//   channel   dir  handshake         payload
//   i_tick    in   valid/ready       tick
//   o_pix     out  valid/ready       led_index, red, green, blue, last
//   i_cfg_*   in   write enable      index 0 led_count, index 1 max_level
//
// A tick with tick set first runs setup (a prep step, two step divisions in rrw_div, the
// start-point search and the first ramp product) and then loads one LED per cycle while
// the sink does not stall. A tick with tick clear is taken and dropped.
// Reset is synchronous and active low; it restores led_count 60 and max_level 120.
// A stalled sink holds the frame at the output register; ticks are taken only between frames.
`timescale 1ns / 1ps

module rotating_rainbow_wave_pattern_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rrw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rrw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rrw_tick_if.sink                       i_tick,
    rrw_pix_if.source                      o_pix
);

    rrw_pkg::t_cmd    w_cmd;
    rrw_pkg::t_status w_status;
    logic             w_idle;
    logic             w_tick_go;

    assign i_tick.ready = w_idle;
    assign w_tick_go    = i_tick.valid && i_tick.ready && i_tick.tick;

    rrw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick_go (w_tick_go),
        .i_status  (w_status),
        .o_cmd     (w_cmd),
        .o_idle    (w_idle)
    );

    rrw_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_pix       (o_pix)
    );

    // A started frame keeps new ticks out until its last LED is loaded.
    a_tick_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick_go |=> !i_tick.ready)
        else $error("tick accepted again right after a frame start");

    // A pixel is only loaded into a free output slot.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_status.slot_free)
        else $error("pixel loaded over an untaken result");

    // Loading the final LED ends the frame and presents it with the last mark.
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_status.last_pixel) |=> (i_tick.ready && o_pix.valid && o_pix.last))
        else $error("frame did not close on its final LED");

endmodule

// ----- hdl/rrw_div.sv -----
// Restoring divider, one quotient bit per cycle, for the per-frame sector step.
// Depends on rrw_pkg for the operand widths.
`timescale 1ns / 1ps

module rrw_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rrw_pkg::LVL_W-1:0]   i_dividend,
    input  logic [rrw_pkg::BASE_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [rrw_pkg::LVL_W-1:0]   o_quotient
);

    localparam int CNT_BITS = $clog2(rrw_pkg::LVL_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_BITS-1:0]         r_cnt;
    logic [rrw_pkg::BASE_W-1:0]  r_rem;
    logic [rrw_pkg::LVL_W-1:0]   r_quo;
    logic [rrw_pkg::BASE_W-1:0]  r_dvs;

    logic [rrw_pkg::BASE_W:0]    w_shift;
    logic [rrw_pkg::BASE_W:0]    w_diff;
    logic                        w_ge;

    assign w_shift = {r_rem, r_quo[rrw_pkg::LVL_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(rrw_pkg::LVL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[rrw_pkg::BASE_W-1:0] : w_shift[rrw_pkg::BASE_W-1:0];
            r_quo <= {r_quo[rrw_pkg::LVL_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- hdl/rrw_ctrl.sv -----
// Frame sequencer: setup, two step divisions, start-point search, then one pixel per slot.
// Depends on rrw_pkg for the state type and the command/status structs.
`timescale 1ns / 1ps

module rrw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tick_go,
    input  rrw_pkg::t_status  i_status,
    output rrw_pkg::t_cmd     o_cmd,
    output logic              o_idle
);

    rrw_pkg::t_state r_state;
    rrw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_idle  = 1'b0;
        case (r_state)
            rrw_pkg::S_IDLE: begin
                o_idle = 1'b1;
                if (i_tick_go) begin
                    o_cmd.start = 1'b1;
                    n_state     = rrw_pkg::S_PREP;
                end
            end
            rrw_pkg::S_PREP: begin
                o_cmd.prep     = 1'b1;
                o_cmd.div_go_a = 1'b1;
                n_state        = rrw_pkg::S_DIV_A;
            end
            rrw_pkg::S_DIV_A: begin
                if (i_status.div_done) begin
                    o_cmd.take_a   = 1'b1;
                    o_cmd.div_go_b = 1'b1;
                    n_state        = rrw_pkg::S_DIV_B;
                end
            end
            rrw_pkg::S_DIV_B: begin
                if (i_status.div_done) begin
                    o_cmd.take_b = 1'b1;
                    n_state      = rrw_pkg::S_SEEK;
                end
            end
            rrw_pkg::S_SEEK: begin
                o_cmd.seek = 1'b1;
                n_state    = rrw_pkg::S_MUL;
            end
            rrw_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = rrw_pkg::S_RUN;
            end
            rrw_pkg::S_RUN: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_pixel) begin
                        n_state = rrw_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = rrw_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/rrw_dpath.sv -----
// Datapath: configuration registers, frame setup values, pixel walkers and output register.
// Depends on rrw_pkg, rrw_pix_if and rrw_div.
`timescale 1ns / 1ps

module rrw_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rrw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rrw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  rrw_pkg::t_cmd                 i_cmd,
    output rrw_pkg::t_status              o_status,
    rrw_pix_if.source                     o_pix
);

    localparam int LV = rrw_pkg::LVL_W;

    // Configuration and frame constants.
    logic [rrw_pkg::CNT_W-1:0]    r_led_count;
    logic [LV-1:0]                r_max_level;
    logic [rrw_pkg::IDX_W-1:0]    r_off;
    logic [rrw_pkg::CNT_W-1:0]    r_n;
    logic [rrw_pkg::BASE_W-1:0]   r_base;
    logic [rrw_pkg::SECT_W-1:0]   r_rest;
    logic [rrw_pkg::THIRD_W-1:0]  r_third;
    logic [LV-1:0]                r_m;
    logic [LV-1:0]                r_diff;
    logic [LV-1:0]                r_lv_d0;
    logic [LV-1:0]                r_lv_d1;
    logic [LV-1:0]                r_lv_d2;
    logic [LV-1:0]                r_lv_d3;
    logic [rrw_pkg::CNT_W-1:0]    r_start [rrw_pkg::SECTORS];
    logic [LV-1:0]                r_step_short;
    logic [LV-1:0]                r_step_long;

    // Pixel walkers.
    logic [rrw_pkg::IDX_W-1:0]    r_i;
    logic [rrw_pkg::IDX_W-1:0]    r_q;
    rrw_pkg::t_sector             r_sec;
    logic [rrw_pkg::P_W-1:0]      r_p;
    logic [LV-1:0]                r_c;
    logic [rrw_pkg::REL_W-1:0]    r_rel [rrw_pkg::WAVES];

    // Output register.
    logic                         r_ov;
    logic [rrw_pkg::IDX_W-1:0]    r_o_idx;
    logic [LV-1:0]                r_o_red;
    logic [LV-1:0]                r_o_green;
    logic [LV-1:0]                r_o_blue;
    logic                         r_o_last;

    logic [rrw_pkg::CNT_W-1:0]    w_eff;
    logic [rrw_pkg::PROD_W-1:0]   w_prod6;
    logic [rrw_pkg::PROD_W-1:0]   w_prod3;
    logic [rrw_pkg::BASE_W-1:0]   w_base;
    logic [rrw_pkg::CNT_W-1:0]    w_six;
    logic [rrw_pkg::IDX_W-1:0]    w_off_inc;
    logic [rrw_pkg::IDX_W-1:0]    n_off;
    logic [LV-1:0]                w_quarter;
    logic [rrw_pkg::CNT_W-1:0]    n_start [rrw_pkg::SECTORS];
    logic [rrw_pkg::REL_W-1:0]    n_rel0 [rrw_pkg::WAVES];
    logic [rrw_pkg::IDX_W-1:0]    w_q0;
    rrw_pkg::t_sector             w_seek_sec;
    logic [rrw_pkg::P_W-1:0]      w_p0;
    logic                         w_long;
    logic [LV-1:0]                w_step;
    logic [rrw_pkg::BASE_W-1:0]   w_len_m1;
    logic [LV-1:0]                w_r;
    logic [LV-1:0]                w_g;
    logic [LV-1:0]                w_b;
    logic [rrw_pkg::ADD_W-1:0]    w_add;
    logic                         w_n_min;
    logic                         w_q_wrap;
    logic                         w_last;
    logic                         w_ld;
    logic [rrw_pkg::BASE_W-1:0]   w_divisor;
    logic                         w_div_done;
    logic [LV-1:0]                w_quotient;

    function automatic logic [LV:0] wave_add(
        input logic [rrw_pkg::REL_W-1:0] rel,
        input logic                      n_min,
        input logic [LV-1:0]             lv0,
        input logic [LV-1:0]             lv1,
        input logic [LV-1:0]             lv2,
        input logic [LV-1:0]             lv3
    );
        logic [LV:0] a;
        // On the shortest strip both ends of a wave land on the same LED.
        case (rel)
            6'd0:    a = {1'b0, lv3} + (n_min ? {1'b0, lv3} : '0);
            6'd1:    a = {1'b0, lv2};
            6'd2:    a = {1'b0, lv1};
            6'd3:    a = {1'b0, lv0};
            6'd4:    a = {1'b0, lv1};
            6'd5:    a = {1'b0, lv2};
            6'd6:    a = {1'b0, lv3};
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic [LV-1:0] sat_add(
        input logic [LV-1:0]             b,
        input logic [rrw_pkg::ADD_W-1:0] a
    );
        logic [rrw_pkg::ADD_W:0] s;
        s = {{(rrw_pkg::ADD_W + 1 - LV){1'b0}}, b} + {1'b0, a};
        return (s > (rrw_pkg::ADD_W + 1)'(rrw_pkg::FULL_LEVEL)) ?
               LV'(rrw_pkg::FULL_LEVEL) : s[LV-1:0];
    endfunction

    // Frame setup values.
    always_comb begin
        if (r_led_count < rrw_pkg::CNT_W'(rrw_pkg::MIN_LEDS)) begin
            w_eff = rrw_pkg::CNT_W'(rrw_pkg::MIN_LEDS);
        end else if (r_led_count > rrw_pkg::CNT_W'(rrw_pkg::MAX_LEDS)) begin
            w_eff = rrw_pkg::CNT_W'(rrw_pkg::MAX_LEDS);
        end else begin
            w_eff = r_led_count;
        end
        w_prod6   = {{(rrw_pkg::PROD_W - rrw_pkg::CNT_W){1'b0}}, w_eff}
                    * rrw_pkg::PROD_W'(rrw_pkg::DIV6_MUL);
        w_prod3   = {{(rrw_pkg::PROD_W - rrw_pkg::CNT_W){1'b0}}, w_eff}
                    * rrw_pkg::PROD_W'(rrw_pkg::DIV3_MUL);
        w_base    = rrw_pkg::BASE_W'(w_prod6 >> rrw_pkg::RECIP_SHIFT);
        w_six     = rrw_pkg::CNT_W'({3'b000, w_base} * rrw_pkg::CNT_W'(rrw_pkg::SECTORS));
        w_off_inc = r_off + 1'b1;
        n_off     = ({1'b0, w_off_inc} >= w_eff) ? '0 : w_off_inc;
        w_quarter = r_diff >> 2;
    end

    always_comb begin
        logic signed [8:0] v;
        logic signed [8:0] sn;
        sn = $signed({2'b00, r_n});
        for (int s = 0; s < rrw_pkg::SECTORS; s++) begin
            n_start[s] = rrw_pkg::CNT_W'(s * r_base)
                         + rrw_pkg::CNT_W'((s < int'(r_rest)) ? s : int'(r_rest));
        end
        // Start of each wave relative to LED 0, normalized with one correction.
        for (int w = 0; w < rrw_pkg::WAVES; w++) begin
            v = 9'sd4 + $signed({3'b000, r_off}) - $signed({2'b00, 7'(w * r_third)});
            if (v < 0) begin
                n_rel0[w] = rrw_pkg::REL_W'(v + sn);
            end else if (v >= sn) begin
                n_rel0[w] = rrw_pkg::REL_W'(v - sn);
            end else begin
                n_rel0[w] = rrw_pkg::REL_W'(v);
            end
        end
    end

    // Start-point search for LED 0 of the frame.
    always_comb begin
        w_q0 = (r_off == '0) ? '0 : rrw_pkg::IDX_W'(r_n - {1'b0, r_off});
        w_seek_sec = rrw_pkg::SEC_GREEN_UP;
        for (int s = 1; s < rrw_pkg::SECTORS; s++) begin
            if ({1'b0, w_q0} >= r_start[s]) begin
                w_seek_sec = rrw_pkg::SECT_W'(s);
            end
        end
        w_p0 = rrw_pkg::P_W'({1'b0, w_q0} - r_start[w_seek_sec]);
    end

    // Colour of the current pixel.
    always_comb begin
        w_long   = r_sec < r_rest;
        w_step   = w_long ? r_step_long : r_step_short;
        w_len_m1 = w_long ? r_base : r_base - 1'b1;
        w_r = '0;
        w_g = '0;
        w_b = '0;
        case (r_sec)
            rrw_pkg::SEC_GREEN_UP: begin
                w_r = r_m;
                w_g = r_c;
            end
            rrw_pkg::SEC_RED_DOWN: begin
                w_r = r_m - r_c;
                w_g = r_m;
            end
            rrw_pkg::SEC_BLUE_UP: begin
                w_g = r_m;
                w_b = r_c;
            end
            rrw_pkg::SEC_GREEN_DOWN: begin
                w_g = r_m - r_c;
                w_b = r_m;
            end
            rrw_pkg::SEC_RED_UP: begin
                w_r = r_c;
                w_b = r_m;
            end
            default: begin
                w_r = r_m;
                w_b = r_m - r_c;
            end
        endcase
        w_n_min = r_n == rrw_pkg::CNT_W'(rrw_pkg::MIN_LEDS);
        w_add   = '0;
        for (int w = 0; w < rrw_pkg::WAVES; w++) begin
            w_add = w_add + rrw_pkg::ADD_W'(wave_add(r_rel[w], w_n_min,
                                                     r_lv_d0, r_lv_d1, r_lv_d2, r_lv_d3));
        end
        w_q_wrap = {1'b0, r_q} == (r_n - 1'b1);
        w_last   = {1'b0, r_i} == (r_n - 1'b1);
    end

    assign w_ld      = i_cmd.emit;
    assign w_divisor = i_cmd.div_go_b ? r_base + 1'b1 : r_base;

    rrw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go_a | i_cmd.div_go_b),
        .i_dividend (r_m),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Control state: configuration, rotation offset and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= rrw_pkg::CNT_W'(rrw_pkg::LED_COUNT_RST);
            r_max_level <= LV'(rrw_pkg::MAX_LEVEL_RST);
            r_off       <= '0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rrw_pkg::CFG_LED_COUNT: r_led_count <= i_cfg_data[rrw_pkg::CNT_W-1:0];
                    rrw_pkg::CFG_MAX_LEVEL: r_max_level <= i_cfg_data[LV-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.start) begin
                r_off <= n_off;
            end
            if (w_ld) begin
                r_ov <= 1'b1;
            end else if (o_pix.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Frame values and walkers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_n     <= w_eff;
            r_base  <= w_base;
            r_rest  <= rrw_pkg::SECT_W'(w_eff - w_six);
            r_third <= rrw_pkg::THIRD_W'(w_prod3 >> rrw_pkg::RECIP_SHIFT);
            r_m     <= r_max_level;
            r_diff  <= LV'(rrw_pkg::FULL_LEVEL) - r_max_level;
        end
        if (i_cmd.prep) begin
            r_start <= n_start;
            r_rel   <= n_rel0;
            r_lv_d0 <= r_diff;
            r_lv_d1 <= r_diff - w_quarter;
            r_lv_d2 <= r_diff - {w_quarter[LV-2:0], 1'b0};
            r_lv_d3 <= r_diff - {w_quarter[LV-2:0], 1'b0} - w_quarter;
            r_i     <= '0;
        end
        if (i_cmd.take_a) begin
            r_step_short <= w_quotient;
        end
        if (i_cmd.take_b) begin
            r_step_long <= w_quotient;
        end
        if (i_cmd.seek) begin
            r_q   <= w_q0;
            r_sec <= w_seek_sec;
            r_p   <= w_p0;
        end
        if (i_cmd.mul) begin
            r_c <= LV'(w_step * r_p);
        end
        if (w_ld) begin
            r_i <= r_i + 1'b1;
            if (w_q_wrap) begin
                r_q   <= '0;
                r_sec <= rrw_pkg::SEC_GREEN_UP;
                r_p   <= '0;
                r_c   <= '0;
            end else begin
                r_q <= r_q + 1'b1;
                if (r_p == w_len_m1) begin
                    r_sec <= r_sec + 1'b1;
                    r_p   <= '0;
                    r_c   <= '0;
                end else begin
                    r_p <= r_p + 1'b1;
                    r_c <= r_c + w_step;
                end
            end
            for (int w = 0; w < rrw_pkg::WAVES; w++) begin
                r_rel[w] <= ({1'b0, r_rel[w]} == (r_n - 1'b1)) ? '0 : r_rel[w] + 1'b1;
            end
            r_o_idx   <= r_i;
            r_o_red   <= sat_add(w_r, w_add);
            r_o_green <= sat_add(w_g, w_add);
            r_o_blue  <= sat_add(w_b, w_add);
            r_o_last  <= w_last;
        end
    end

    assign o_status.div_done   = w_div_done;
    assign o_status.slot_free  = !r_ov || o_pix.ready;
    assign o_status.last_pixel = w_last;

    assign o_pix.valid     = r_ov;
    assign o_pix.led_index = r_o_idx;
    assign o_pix.red       = r_o_red;
    assign o_pix.green     = r_o_green;
    assign o_pix.blue      = r_o_blue;
    assign o_pix.last      = r_o_last;

endmodule

// ----- tb/rrw_frame_checker.sv -----
// Frame checker for the rotating rainbow wave unit: predicts every LED colour of a frame and
// compares the pixel transactions against it. Depends on rrw_pkg, rrw_tick_if and rrw_pix_if.
`timescale 1ns / 1ps

module rrw_frame_checker
    import rrw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rrw_tick_if                   tick_mon,
    rrw_pix_if                    pix_mon,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [IDX_W-1:0] led_index;
        logic [LVL_W-1:0] red;
        logic [LVL_W-1:0] green;
        logic [LVL_W-1:0] blue;
        logic             last;
    } t_pixel;

    logic [CNT_W-1:0] led_count_reg;
    logic [LVL_W-1:0] max_level_reg;
    logic [IDX_W-1:0] rotation;
    t_pixel           expected_pixels[$];

    task automatic note_mismatch(input string msg);
        o_fail_count++;
        // Keep the log readable when everything goes wrong.
        if (o_fail_count <= 100) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic int saturate(input int level);
        return (level > FULL_LEVEL) ? FULL_LEVEL : level;
    endfunction

    // Advances the rotation and queues the colours of one whole frame.
    function automatic void paint_frame();
        int     n, base, rest, first, len, step, lvl, ramp, pos;
        int     diff, quarter, centre, span, bump;
        int     s, p, w, k, i;
        int     red_lvl[MAX_LEDS];
        int     green_lvl[MAX_LEDS];
        int     blue_lvl[MAX_LEDS];
        t_pixel px;

        if (led_count_reg < MIN_LEDS) n = MIN_LEDS;
        else if (led_count_reg > MAX_LEDS) n = MAX_LEDS;
        else n = int'(led_count_reg);
        lvl = int'(max_level_reg);

        rotation = rotation + 1'b1;
        if (int'(rotation) >= n) rotation = '0;

        for (i = 0; i < MAX_LEDS; i++) begin
            red_lvl[i]   = 0;
            green_lvl[i] = 0;
            blue_lvl[i]  = 0;
        end

        // Six sectors end to end from the rotation point; the first n%6 are one LED longer.
        base  = n / SECTORS;
        rest  = n % SECTORS;
        first = 0;
        for (s = 0; s < SECTORS; s++) begin
            len  = base + ((s < rest) ? 1 : 0);
            step = lvl / len;
            for (p = 0; p < len; p++) begin
                ramp = step * p;
                pos  = (int'(rotation) + first + p) % n;
                case (t_sector'(s))
                    SEC_GREEN_UP: begin
                        red_lvl[pos]   = lvl;
                        green_lvl[pos] = ramp;
                    end
                    SEC_RED_DOWN: begin
                        red_lvl[pos]   = lvl - ramp;
                        green_lvl[pos] = lvl;
                    end
                    SEC_BLUE_UP: begin
                        green_lvl[pos] = lvl;
                        blue_lvl[pos]  = ramp;
                    end
                    SEC_GREEN_DOWN: begin
                        green_lvl[pos] = lvl - ramp;
                        blue_lvl[pos]  = lvl;
                    end
                    SEC_RED_UP: begin
                        red_lvl[pos]  = ramp;
                        blue_lvl[pos] = lvl;
                    end
                    default: begin
                        red_lvl[pos]  = lvl;
                        blue_lvl[pos] = lvl - ramp;
                    end
                endcase
            end
            first += len;
        end

        // Waves run against the rotation and stack with saturation where they overlap.
        diff    = FULL_LEVEL - lvl;
        quarter = diff / 4;
        for (w = 0; w < WAVES; w++) begin
            centre = (n - 1) - int'(rotation) + w * (n / 3);
            for (k = 0; k <= 2 * WAVE_REACH; k++) begin
                pos            = (centre + n + k - WAVE_REACH) % n;
                span           = (k > WAVE_REACH) ? k - WAVE_REACH : WAVE_REACH - k;
                bump           = diff - span * quarter;
                red_lvl[pos]   = saturate(red_lvl[pos] + bump);
                green_lvl[pos] = saturate(green_lvl[pos] + bump);
                blue_lvl[pos]  = saturate(blue_lvl[pos] + bump);
            end
        end

        for (i = 0; i < n; i++) begin
            px.led_index = i[IDX_W-1:0];
            px.red       = red_lvl[i][LVL_W-1:0];
            px.green     = green_lvl[i][LVL_W-1:0];
            px.blue      = blue_lvl[i][LVL_W-1:0];
            px.last      = (i == n - 1);
            expected_pixels.push_back(px);
        end
    endfunction

    task automatic compare_field(input string field, input int got, input int want,
                                 input int led);
        if (got != want) begin
            note_mismatch($sformatf("LED %0d %s: got %0d, expected %0d", led, field, got, want));
        end
    endtask

    task automatic check_pixel();
        t_pixel want;

        if (expected_pixels.size() == 0) begin
            note_mismatch($sformatf("pixel for LED %0d arrived with no frame pending",
                                    pix_mon.led_index));
        end else begin
            want = expected_pixels.pop_front();
            compare_field("led_index", int'(pix_mon.led_index), int'(want.led_index),
                          int'(want.led_index));
            compare_field("red", int'(pix_mon.red), int'(want.red), int'(want.led_index));
            compare_field("green", int'(pix_mon.green), int'(want.green),
                          int'(want.led_index));
            compare_field("blue", int'(pix_mon.blue), int'(want.blue), int'(want.led_index));
            compare_field("last", int'(pix_mon.last), int'(want.last), int'(want.led_index));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            led_count_reg = LED_COUNT_RST;
            max_level_reg = MAX_LEVEL_RST;
            rotation      = '0;
            o_fail_count  = 0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LED_COUNT: led_count_reg = i_cfg_data[CNT_W-1:0];
                    CFG_MAX_LEVEL: max_level_reg = i_cfg_data[LVL_W-1:0];
                    default: begin
                    end
                endcase
            end
            // A pixel seen on the same edge as a tick still belongs to the older frame.
            if (pix_mon.valid && pix_mon.ready) begin
                check_pixel();
            end
            if (tick_mon.valid && tick_mon.ready && tick_mon.tick) begin
                paint_frame();
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the rotating rainbow wave testbench: clock, reset, tick and register stimulus,
// random sink stalls and the verdict. Depends on rrw_pkg, both channel interfaces, the unit
// and rrw_frame_checker.
`timescale 1ns / 1ps

module testbench;
    import rrw_pkg::*;

    localparam int RANDOM_FRAMES = 160;
    localparam int SETTLE_CYCLES = 30;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int src_idle_pct  = 23;
    int sink_idle_pct = 23;
    int frames_sent   = 0;

    rrw_tick_if tick_ch ();
    rrw_pix_if  pix_ch ();

    rotating_rainbow_wave_pattern_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tick      (tick_ch),
        .o_pix       (pix_ch)
    );

    rrw_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .tick_mon     (tick_ch),
        .pix_mon      (pix_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        pix_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            pix_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic sender_gap();
        if ($urandom_range(99) < src_idle_pct) begin
            tick_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    // Returns on the edge at which the transaction is accepted; valid stays high.
    task automatic offer_tick(input logic tick_bit);
        sender_gap();
        tick_ch.valid <= 1'b1;
        tick_ch.tick  <= tick_bit;
        @(posedge i_clk);
        while (!tick_ch.ready) @(posedge i_clk);
        if (tick_bit) frames_sent++;
    endtask

    // Holds the sender off until every predicted pixel has been taken.
    task automatic drain();
        tick_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CNT_W-1:0] count, input logic [LVL_W-1:0] level);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LED_COUNT;
        i_cfg_data  <= CFG_DATA_W'(count);
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_LEVEL;
        i_cfg_data  <= level;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_ticks(input int count);
        int i;

        for (i = 0; i < count; i++) begin
            offer_tick($urandom_range(99) >= 10);
            if ($urandom_range(99) < 6) drain();
        end
    endtask

    initial begin
        int               phase;
        int               start;
        logic [CNT_W-1:0] count;
        logic [LVL_W-1:0] level;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_LED_COUNT;
        i_cfg_data    = '0;
        tick_ch.valid = 1'b0;
        tick_ch.tick  = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings, with a dropped tick; the rotation ends up past six.
        offer_tick(1'b1);
        offer_tick(1'b0);
        repeat (7) offer_tick(1'b1);
        drain();
        // Count below the minimum shrinks the strip under the rotation; no wave headroom.
        set_config(7'd5, 8'd255);
        repeat (2) offer_tick(1'b1);
        drain();
        // Zero count and a black rainbow with full-strength waves.
        set_config(7'd0, 8'd0);
        offer_tick(1'b1);
        offer_tick(1'b0);
        offer_tick(1'b1);
        drain();
        // Smallest strip: the rotation wraps and the waves overlap heavily.
        set_config(7'd6, 8'd1);
        repeat (6) offer_tick(1'b1);
        drain();
        set_config(7'd64, 8'd255);
        repeat (2) offer_tick(1'b1);
        drain();
        // Count above the maximum acts as the full strip.
        set_config(7'd127, 8'd1);
        offer_tick(1'b1);
        drain();
        set_config(7'd7, 8'd128);
        repeat (2) offer_tick(1'b1);
        drain();

        phase = 0;
        start = frames_sent;
        while (frames_sent - start < RANDOM_FRAMES) begin
            // One phase runs with neither side idling.
            src_idle_pct  = (phase == 1) ? 0 : 23;
            sink_idle_pct = (phase == 1) ? 0 : 23;
            case ($urandom_range(9))
                0: count = CNT_W'($urandom_range(0, MIN_LEDS - 1));
                1: count = CNT_W'($urandom_range(MAX_LEDS + 1, 127));
                2: count = $urandom_range(1) ? CNT_W'(MIN_LEDS) : CNT_W'(MAX_LEDS);
                default: count = CNT_W'($urandom_range(MIN_LEDS, MAX_LEDS));
            endcase
            if ($urandom_range(99) < 15) begin
                case ($urandom_range(3))
                    0: level = 8'd0;
                    1: level = 8'd1;
                    2: level = 8'd254;
                    default: level = 8'd255;
                endcase
            end else begin
                level = LVL_W'($urandom_range(0, 255));
            end
            set_config(count, level);
            run_ticks($urandom_range(4, 20));
            drain();
            phase++;
        end

        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
